// ===== rtl/wrms_pkg.sv =====
`default_nettype none
package wrms_pkg;

  localparam int unsigned ChW   = 8;
  localparam int unsigned DataW = 32;
  localparam int unsigned SumW  = 64;
  localparam int unsigned CfgW  = 9;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_LOAD,
    ST_DIVM,
    ST_MEAN,
    ST_MUL,
    ST_ACC,
    ST_DIVV,
    ST_SQRT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [ChW-1:0]   channel;
    logic [DataW-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [ChW-1:0]   channel_out;
    logic [DataW-1:0] count;
    logic [DataW-1:0] mean;
    logic [DataW-1:0] stdev;
    logic             stdev_valid;
    logic             error;
  } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/wrms_stream_if.sv =====
`default_nettype none
interface wrms_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/welford_running_mean_stdev.sv =====
`default_nettype none
// Per-channel running mean and sample standard deviation (Welford update).
// One transaction in gives one transaction out. The arithmetic is bit-serial:
// the mean division, the 33x33-bit residual product, the variance division
// and the square root each retire one bit per cycle. The first sample of a
// channel skips the variance division and the square root. An out-of-range
// channel has its result valid the cycle after acceptance. A new sample is
// taken the cycle after the previous result is accepted. Statistics live in
// one memory with a single read/write port. After reset and after each write
// of channels_used, a clearing pass zeroes all MAX_CHANNELS entries of the
// memory and no sample is taken meanwhile.
module welford_running_mean_stdev #(
  parameter int unsigned MAX_CHANNELS = 256
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   cfg_we_i,
  input  wire logic [wrms_pkg::CfgW-1:0] cfg_wdata_i,
  wrms_stream_if.sink   in_if,
  wrms_stream_if.source out_if
);
  import wrms_pkg::*;

  localparam int unsigned AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned MemW = DataW + DataW + SumW;

  // statistics memory: {count, mean, sum}
  logic [MemW-1:0] mem_q [MAX_CHANNELS];
  logic [MemW-1:0] rd_q;
  logic            mem_we;
  logic [AW-1:0]   mem_addr;
  logic [MemW-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    rd_q <= mem_q[mem_addr];
  end

  state_e state_q, state_d;
  logic [CfgW-1:0] used_q;
  logic [AW:0]     clr_q;
  logic [AW-1:0]   addr_q;
  logic signed [DataW:0] x_q;
  logic [DataW-1:0] n_q;
  logic signed [DataW:0] m_q;
  logic [SumW-1:0] s_q;
  logic            err_q;
  logic            neg_q;
  logic [6:0]      cnt_q;
  // shared serial divider: quotient/dividend shift reg, remainder, divisor
  logic [SumW-1:0] quo_q;
  logic [SumW:0]   rem_q;
  logic [DataW-1:0] dv_q;
  // serial multiplier
  logic [SumW-1:0] acc_q;
  logic [DataW:0]  ma_q, mb_q;
  // sqrt
  logic [SumW-1:0] sv_q, sres_q, sbit_q;
  out_item_t       res_q;
  logic            res_vld_q;

  logic in_range;
  logic [SumW:0] rem_sh;
  logic [SumW+1:0] s_sum;
  logic signed [DataW+1:0] mnew;
  logic [DataW:0] resid;

  // channel must be below both channels_used and MAX_CHANNELS
  assign in_range = (32'(in_if.data.channel) < 32'(used_q)) &&
                    (32'(in_if.data.channel) < MAX_CHANNELS);

  assign rem_sh = {rem_q[SumW-1:0], quo_q[SumW-1]};
  assign mnew  = {m_q[DataW], m_q} + (neg_q ? -$signed({1'b0, quo_q[DataW:0]})
                                            : $signed({1'b0, quo_q[DataW:0]}));
  assign resid = x_q - mnew[DataW:0];
  assign s_sum = {1'b0, s_q} + {1'b0, acc_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_if.valid && !res_vld_q) state_d = in_range ? ST_READ : ST_IDLE;
      ST_CLEAR: if (clr_q == (AW+1)'(MAX_CHANNELS - 1)) state_d = ST_IDLE;
      ST_READ:  state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_DIVM;
      ST_DIVM:  if (cnt_q == 7'd32) state_d = ST_MEAN;
      ST_MEAN:  state_d = ST_MUL;
      ST_MUL:   if (cnt_q == 7'd63) state_d = ST_ACC;
      ST_ACC:   state_d = (n_q > 32'd1) ? ST_DIVV : ST_OUT;
      ST_DIVV:  if (cnt_q == 7'd63) state_d = ST_SQRT;
      ST_SQRT:  if (sbit_q == '0) state_d = ST_OUT;
      ST_OUT:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
    if (cfg_we_i) state_d = ST_CLEAR;
  end

  // memory port
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = addr_q;
    mem_wdata = {n_q, m_q[DataW-1:0], s_q};
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_addr = clr_q[AW-1:0];
        mem_wdata = '0;
      end
      ST_IDLE: mem_addr = AW'(in_if.data.channel);
      ST_OUT: mem_we = 1'b1;
      default: ;
    endcase
  end

  assign in_if.ready  = (state_q == ST_IDLE) && !res_vld_q && !cfg_we_i;
  assign out_if.valid = res_vld_q;
  assign out_if.data  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      used_q    <= CfgW'(256);
      clr_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) used_q <= cfg_wdata_i;
      if (state_q == ST_CLEAR && !cfg_we_i) clr_q <= clr_q + 1'b1;
      else clr_q <= '0;
      if (out_if.valid && out_if.ready) res_vld_q <= 1'b0;
      if (state_q == ST_IDLE && in_if.valid && in_if.ready && !in_range) res_vld_q <= 1'b1;
      if (state_q == ST_OUT) res_vld_q <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        // hold the pending result until it is taken
        if (in_if.ready) begin
          addr_q <= AW'(in_if.data.channel);
          x_q    <= {in_if.data.sample[DataW-1], in_if.data.sample};
          res_q  <= '{channel_out: in_if.data.channel, count: '0, mean: '0, stdev: '0,
                      stdev_valid: 1'b0, error: 1'b1};
          err_q  <= 1'b0;
        end
      end
      ST_LOAD: begin
        n_q <= (rd_q[MemW-1 -: DataW] == '1) ? '1 : rd_q[MemW-1 -: DataW] + 1'b1;
        m_q <= {rd_q[SumW+DataW-1], rd_q[SumW +: DataW]};
        s_q <= rd_q[SumW-1:0];
        begin : ld_delta
          logic signed [DataW:0] d;
          d = x_q - {rd_q[SumW+DataW-1], rd_q[SumW +: DataW]};
          neg_q <= d[DataW];
          quo_q <= {{(SumW-DataW-1){1'b0}}, (d[DataW] ? -d : d)} << (SumW-DataW-1);
          ma_q  <= d[DataW] ? -d : d;
        end
        dv_q  <= (rd_q[MemW-1 -: DataW] == '1) ? '1 : rd_q[MemW-1 -: DataW] + 1'b1;
        rem_q <= '0;
        cnt_q <= '0;
      end
      ST_DIVM, ST_DIVV: begin
        cnt_q <= cnt_q + 1'b1;
        if (rem_sh >= {{(SumW-DataW+1){1'b0}}, dv_q}) begin
          rem_q <= rem_sh - {{(SumW-DataW+1){1'b0}}, dv_q};
          quo_q <= {quo_q[SumW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[SumW-2:0], 1'b0};
        end
      end
      ST_MEAN: begin
        m_q   <= mnew[DataW:0];
        mb_q  <= resid[DataW] ? -resid : resid;
        acc_q <= '0;
        cnt_q <= '0;
      end
      ST_MUL: begin
        cnt_q <= cnt_q + 1'b1;
        // shift-add, LSB of mb first; products fit 64 bits
        if (mb_q[0]) acc_q <= acc_q + ({{(SumW-DataW-1){1'b0}}, ma_q} << cnt_q[5:0]);
        mb_q <= mb_q >> 1;
      end
      ST_ACC: begin
        if (s_sum[SumW]) begin
          s_q <= '1;
          err_q <= 1'b1;
        end else begin
          s_q <= s_sum[SumW-1:0];
        end
        quo_q <= s_sum[SumW] ? '1 : s_sum[SumW-1:0];
        dv_q  <= n_q - 1'b1;
        rem_q <= '0;
        cnt_q <= '0;
      end
      ST_SQRT: begin
        if (sbit_q != '0) begin
          if (sv_q >= sres_q + sbit_q) begin
            sv_q   <= sv_q - (sres_q + sbit_q);
            sres_q <= (sres_q >> 1) + sbit_q;
          end else begin
            sres_q <= sres_q >> 1;
          end
          sbit_q <= sbit_q >> 2;
        end
      end
      ST_OUT: begin
        res_q.count       <= n_q;
        res_q.mean        <= m_q[DataW-1:0];
        res_q.stdev       <= (n_q > 32'd1) ? sres_q[DataW-1:0] : '0;
        res_q.stdev_valid <= (n_q > 32'd1);
        res_q.error       <= err_q;
      end
      default: ;
    endcase
    // load sqrt operands as the variance division finishes
    if (state_q == ST_DIVV && cnt_q == 7'd63) begin
      sv_q   <= {quo_q[SumW-2:0], (rem_sh >= {{(SumW-DataW+1){1'b0}}, dv_q})};
      sres_q <= '0;
      sbit_q <= {2'b01, {(SumW-2){1'b0}}};
    end
  end

endmodule
`default_nettype wire
